>>> design/kte_pkg.sv
// ----------------------------------------------------------------------------
// kte_pkg: shared definitions for the streaming kth extreme tracker
// Widths, rank depths, sentinels and the link type passed between rank cells.
// ----------------------------------------------------------------------------
package kte_pkg;

  localparam int DATA_W      = 32;
  localparam int LEN_W       = 16;
  localparam int TOP_RANK    = 3;
  localparam int BOTTOM_RANK = 5;

  localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [LEN_W-1:0]         LEN_RESET = LEN_W'(10);

  // what a rank cell hands to the next cell down the chain
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     hit;
  } kte_link_t;

endpackage

>>> design/kte_in_if.sv
// ----------------------------------------------------------------------------
// kte_in_if: sample input channel
// Valid/ready channel carrying one signed sample per transfer.
// ----------------------------------------------------------------------------
interface kte_in_if import kte_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> design/kte_out_if.sv
// ----------------------------------------------------------------------------
// kte_out_if: result output channel
// Valid/ready channel carrying one set result per transfer.
// ----------------------------------------------------------------------------
interface kte_out_if import kte_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] third_largest;
  logic signed [DATA_W-1:0] fifth_smallest;
  logic signed [DATA_W-1:0] middle_value;

  modport source (output valid, output third_largest, output fifth_smallest,
                  output middle_value, input ready);
  modport sink   (input valid, input third_largest, input fifth_smallest,
                  input middle_value, output ready);
endinterface

>>> design/kte_rank_cell.sv
// ----------------------------------------------------------------------------
// kte_rank_cell: one rank of a sorted insertion chain
// Holds one ranked value; takes the sample or the upper neighbor's value.
// ----------------------------------------------------------------------------
module kte_rank_cell import kte_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     desc_mode,  // 1: largest chain, 0: smallest chain
  input  logic                     load,
  input  logic                     clear,
  input  logic signed [DATA_W-1:0] sample,
  input  kte_link_t                link_in,
  output kte_link_t                link_out,
  output logic signed [DATA_W-1:0] val_nxt
);

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] sentinel;
  logic                     hit;

  assign sentinel = desc_mode ? MOST_NEG : MOST_POS;

  // strict compare, so equal values stay below the ones already held
  assign hit = desc_mode ? (sample > val_r) : (sample < val_r);

  // upper neighbor shifting down wins, else insert here, else hold
  always_comb begin
    if (link_in.hit) begin
      val_nxt = link_in.val;
    end else if (hit) begin
      val_nxt = sample;
    end else begin
      val_nxt = val_r;
    end
  end

  assign link_out = '{val: val_r, hit: hit};

  // rank register, back to sentinel on reset or end of set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= sentinel;
    end else if (load) begin
      val_r <= clear ? sentinel : val_nxt;
    end
  end

endmodule

>>> design/streaming_kth_extreme_tracker.sv
// ----------------------------------------------------------------------------
// streaming_kth_extreme_tracker: per-set third largest, fifth smallest, middle
// Two chains of rank cells sort each sample in as it arrives; the last sample
// of a set produces one result and clears the chains.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  in_ch    | in  | valid/ready         | sample
//  out_ch   | out | valid/ready         | third_largest, fifth_smallest,
//           |     |                     | middle_value
//  cfg_*    | in  | cfg_we, no ready    | cfg_wdata = set_length
//
//  One sample is taken every cycle unless a set-closing sample must wait on
//  a stalled result; each rank cell compares and shifts in the same cycle,
//  and the closing result is registered in the cycle after its transfer.
//  Reset loads the sentinels into all ranks, zeroes the count and middle hold
//  and sets set_length to 10.
//  A stalled result blocks only the next set-closing sample; other samples
//  keep flowing.
// ----------------------------------------------------------------------------
module streaming_kth_extreme_tracker import kte_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  kte_in_if.sink           in_ch,
  kte_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  logic [LEN_W-1:0]         set_length_r;
  logic [LEN_W-1:0]         cnt_r;
  logic [LEN_W-1:0]         cnt_nxt;
  logic signed [DATA_W-1:0] mid_r;
  logic signed [DATA_W-1:0] mid_nxt;
  logic [LEN_W-1:0]         len;
  logic [LEN_W-1:0]         mid_pos;
  logic                     at_mid;
  logic                     closes;
  logic                     in_xfer;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] third_r;
  logic signed [DATA_W-1:0] fifth_r;
  logic signed [DATA_W-1:0] middle_r;

  kte_link_t                lg_link [TOP_RANK+1];
  kte_link_t                sm_link [BOTTOM_RANK+1];
  logic signed [DATA_W-1:0] lg_nxt  [TOP_RANK];
  logic signed [DATA_W-1:0] sm_nxt  [BOTTOM_RANK];

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_length_r <= LEN_RESET;
    end else if (cfg_we) begin
      set_length_r <= cfg_wdata;
    end
  end

  // set position tracking; zero length acts as one
  assign len     = (set_length_r == '0) ? LEN_W'(1) : set_length_r;
  assign mid_pos = len >> 1;
  assign at_mid  = (cnt_r == mid_pos);
  assign closes  = ({1'b0, cnt_r} + (LEN_W+1)'(1)) >= {1'b0, len};
  assign cnt_nxt = closes ? '0 : cnt_r + LEN_W'(1);
  assign mid_nxt = at_mid ? in_ch.sample : mid_r;

  // only a set-closing sample needs the output register free
  assign in_ch.ready = !out_valid_r || out_ch.ready || !closes;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      mid_r <= '0;
    end else if (in_xfer) begin
      cnt_r <= cnt_nxt;
      mid_r <= closes ? '0 : mid_nxt;
    end
  end

  // largest chain, descending
  assign lg_link[0] = '{val: MOST_NEG, hit: 1'b0};

  for (genvar i = 0; i < TOP_RANK; i++) begin : g_lg
    kte_rank_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .desc_mode (1'b1),
      .load      (in_xfer),
      .clear     (closes),
      .sample    (in_ch.sample),
      .link_in   (lg_link[i]),
      .link_out  (lg_link[i+1]),
      .val_nxt   (lg_nxt[i])
    );
  end

  // smallest chain, ascending
  assign sm_link[0] = '{val: MOST_POS, hit: 1'b0};

  for (genvar i = 0; i < BOTTOM_RANK; i++) begin : g_sm
    kte_rank_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .desc_mode (1'b0),
      .load      (in_xfer),
      .clear     (closes),
      .sample    (in_ch.sample),
      .link_in   (sm_link[i]),
      .link_out  (sm_link[i+1]),
      .val_nxt   (sm_nxt[i])
    );
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && closes) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload, captured from the ranks after the closing insert
  always_ff @(posedge clk) begin
    if (in_xfer && closes) begin
      third_r  <= lg_nxt[TOP_RANK-1];
      fifth_r  <= sm_nxt[BOTTOM_RANK-1];
      middle_r <= mid_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.third_largest  = third_r;
  assign out_ch.fifth_smallest = fifth_r;
  assign out_ch.middle_value   = middle_r;

`ifndef SYNTHESIS
  // a closing transfer always produces a result next cycle
  a_close_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && closes) |=> out_valid_r)
    else $error("closing sample produced no result");

  // a closing transfer restarts the set count
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && closes) |=> (cnt_r == '0 && mid_r == '0))
    else $error("set state not cleared after close");

  // a pending result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !(in_xfer && closes))
    else $error("result overwritten while stalled");

  // chains stay sorted end to end
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (lg_link[1].val >= lg_link[TOP_RANK].val) &&
    (sm_link[1].val <= sm_link[BOTTOM_RANK].val))
    else $error("rank chain out of order");
`endif

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the streaming kth extreme tracker
// Drives signed samples through the valid/ready input channel under random
// gaps and receiver stalls, rewrites the set length between phases, and
// checks each set result against an order-statistic predictor kept in a
// small scoreboard class.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [kte_pkg::DATA_W-1:0] third_largest;
  logic signed [kte_pkg::DATA_W-1:0] fifth_smallest;
  logic signed [kte_pkg::DATA_W-1:0] middle_value;
} set_result_t;

// tracks the running ranks of the open set and the results still owed
class order_stat_board;
  bit [kte_pkg::LEN_W-1:0]           set_len;
  logic signed [kte_pkg::DATA_W-1:0] top_vals[kte_pkg::TOP_RANK];
  logic signed [kte_pkg::DATA_W-1:0] bottom_vals[kte_pkg::BOTTOM_RANK];
  logic signed [kte_pkg::DATA_W-1:0] mid_hold;
  int unsigned                       fill_count;
  set_result_t                       expected_sets[$];
  int unsigned                       results_seen;
  int unsigned                       mismatches;

  function new();
    set_len      = kte_pkg::LEN_RESET;
    results_seen = 0;
    mismatches   = 0;
    clear_set();
  endfunction

  function void clear_set();
    for (int i = 0; i < kte_pkg::TOP_RANK; i++) top_vals[i] = kte_pkg::MOST_NEG;
    for (int i = 0; i < kte_pkg::BOTTOM_RANK; i++) bottom_vals[i] = kte_pkg::MOST_POS;
    fill_count = 0;
    mid_hold   = '0;
  endfunction

  function void write_length(input bit [kte_pkg::LEN_W-1:0] v);
    set_len = v;
  endfunction

  // one accepted sample transfer
  function void take_sample(input logic signed [kte_pkg::DATA_W-1:0] x);
    int unsigned len;
    bit          placed;
    set_result_t res;
    // zero length behaves as one
    len = (set_len == 0) ? 1 : set_len;

    // strict-compare insertion, equal values take separate ranks
    placed = 0;
    for (int r = 0; r < kte_pkg::TOP_RANK; r++) begin
      if (!placed && x > top_vals[r]) begin
        for (int k = kte_pkg::TOP_RANK - 1; k > r; k--) top_vals[k] = top_vals[k-1];
        top_vals[r] = x;
        placed = 1;
      end
    end
    placed = 0;
    for (int r = 0; r < kte_pkg::BOTTOM_RANK; r++) begin
      if (!placed && x < bottom_vals[r]) begin
        for (int k = kte_pkg::BOTTOM_RANK - 1; k > r; k--) bottom_vals[k] = bottom_vals[k-1];
        bottom_vals[r] = x;
        placed = 1;
      end
    end

    if (fill_count == len / 2) mid_hold = x;

    // closing sample, also when the length was lowered below the count
    if (fill_count + 1 >= len) begin
      res.third_largest  = top_vals[kte_pkg::TOP_RANK-1];
      res.fifth_smallest = bottom_vals[kte_pkg::BOTTOM_RANK-1];
      res.middle_value   = mid_hold;
      expected_sets.push_back(res);
      clear_set();
    end else begin
      fill_count = (fill_count + 1) & 32'hFFFF;
    end
  endfunction

  // one accepted result transfer
  function void check_result(input set_result_t got);
    set_result_t want;
    if (expected_sets.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: third %0d fifth %0d middle %0d",
                 got.third_largest, got.fifth_smallest, got.middle_value);
      return;
    end
    want = expected_sets.pop_front();
    results_seen++;
    if (want.third_largest !== got.third_largest ||
        want.fifth_smallest !== got.fifth_smallest ||
        want.middle_value !== got.middle_value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d differs: expected third %0d fifth %0d middle %0d, got %0d %0d %0d",
                 results_seen, want.third_largest, want.fifth_smallest, want.middle_value,
                 got.third_largest, got.fifth_smallest, got.middle_value);
    end
  endfunction
endclass

module tb_top;
  import kte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  kte_in_if  in_ch ();
  kte_out_if out_ch ();

  order_stat_board board = new();

  bit quiet_phase = 1'b0;
  int receiver_hold = 0;
  int longest_hold = 0;
  int samples_sent = 0;
  int length_writes = 0;

  streaming_kth_extreme_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // observe register writes and transfers on both channels
  always @(posedge clk) begin : observe
    set_result_t got;
    if (rst_n) begin
      if (cfg_we) board.write_length(cfg_wdata);
      if (in_ch.valid && in_ch.ready) board.take_sample(in_ch.sample);
      if (out_ch.valid && out_ch.ready) begin
        got.third_largest  = out_ch.third_largest;
        got.fifth_smallest = out_ch.fifth_smallest;
        got.middle_value   = out_ch.middle_value;
        board.check_result(got);
      end
    end
  end

  // mostly short pauses, a few long ones
  function automatic int pick_pause(input int idle_pct);
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r >= idle_pct) return 0;
    if (r >= idle_pct / 5) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [DATA_W-1:0] next_sample(
    input logic signed [DATA_W-1:0] prev);
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 5) return $urandom;
    if (kind < 8) return $signed(DATA_W'($urandom_range(0, 8))) - 4;
    if (kind == 8) begin
      if ($urandom_range(0, 1)) return MOST_NEG + DATA_W'($urandom_range(0, 2));
      return MOST_POS - DATA_W'($urandom_range(0, 2));
    end
    return prev;
  endfunction

  // offer one sample and hold it until the transfer
  task automatic send_sample(input logic signed [DATA_W-1:0] v);
    int gap;
    in_ch.valid  <= 1'b1;
    in_ch.sample <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent++;
    gap = pick_pause(40);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every owed result has been taken
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_sets.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_length(input logic [LEN_W-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    length_writes++;
  endtask

  // receiver: random stalls, plus a long hold when requested
  initial begin : receiver
    int stall;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_hold > 0) begin
        stall = receiver_hold;
        receiver_hold = 0;
        if (stall > longest_hold) longest_hold = stall;
      end else begin
        stall = pick_pause(20);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // stimulus
  initial begin : stimulus
    logic signed [DATA_W-1:0] v;
    logic [LEN_W-1:0]         new_len;
    int pick, eff, count, random_start;

    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length of ten, extremes and duplicates
    send_sample(MOST_POS);
    send_sample(MOST_NEG);
    send_sample(0);
    send_sample(-1);
    send_sample(1);
    send_sample(5);
    send_sample(5);
    send_sample(5);
    send_sample(-7);
    send_sample(MOST_NEG);

    // single-sample sets: the closing sample is also the middle
    load_length(1);
    send_sample(MOST_NEG);
    send_sample(MOST_POS);

    // zero length acts as one
    load_length(0);
    send_sample(42);
    send_sample(-42);

    // short set with equal values, lower ranks stay at their sentinels
    load_length(3);
    send_sample(7);
    send_sample(7);
    send_sample(7);

    // longest length, then lowered mid-set before the middle is reached
    load_length(16'hFFFF);
    send_sample(MOST_POS);
    send_sample(-3);
    send_sample(9);
    send_sample(MOST_NEG);
    load_length(2);
    send_sample(11);

    // receiver holds off while the sender keeps offering closing samples
    load_length(1);
    quiet_phase = 1'b1;
    receiver_hold = 300;
    v = 0;
    repeat (40) begin
      v = next_sample(v);
      send_sample(v);
    end
    quiet_phase = 1'b0;

    // random phases, each with a fresh length
    random_start = samples_sent;
    while (samples_sent - random_start < 1750) begin
      quiet_phase = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0)      new_len = 0;
      else if (pick == 1) new_len = 1;
      else if (pick == 2) new_len = LEN_W'($urandom_range(1000, 65535));
      else if (pick < 8)  new_len = LEN_W'($urandom_range(2, 6));
      else if (pick < 16) new_len = LEN_W'($urandom_range(7, 16));
      else                new_len = LEN_W'($urandom_range(17, 64));
      load_length(new_len);

      if (pick == 2) begin
        // long set cut short by the next length write
        count = $urandom_range(1, 24);
      end else begin
        eff = (new_len == 0) ? 1 : new_len;
        count = eff * $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) count += $urandom_range(1, eff);
      end
      repeat (count) begin
        v = next_sample(v);
        send_sample(v);
      end
    end
    quiet_phase = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);

    $display("covered %0d samples and %0d set results over %0d length writes",
             samples_sent, board.results_seen, length_writes);
    $display("longest receiver hold %0d cycles, %0d results still owed",
             longest_hold, board.expected_sets.size());
    if (board.mismatches == 0 && board.expected_sets.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatches counted", board.mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> streaming_kth_extreme_tracker.f
design/kte_pkg.sv
design/kte_in_if.sv
design/kte_out_if.sv
design/kte_rank_cell.sv
design/streaming_kth_extreme_tracker.sv
bench/tb_top.sv
